[hw/rtl/mhfa_pkg.sv]
`timescale 1ns / 1ps
package mhfa_pkg;
    localparam int HeapBytes = 1048576;
    localparam int HeapSlots = 8;
    localparam int SegSlots = 64;
    localparam int SegW = $clog2(SegSlots);
    localparam int LinkW = SegW + 1;
    localparam logic [LinkW-1:0] NilLink = LinkW'(SegSlots);

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_HEAP = 2'd2,
        ST_TABLE_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [23:0] req_size;
        logic [2:0]  blk_heap;
        logic [19:0] blk_offset;
        logic [20:0] blk_size;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  got_heap;
        logic [19:0] got_offset;
        logic [20:0] got_size;
        logic        heap_added;
        logic        heap_released;
    } t_rsp;

    typedef struct packed {
        logic [2:0]       heap;
        logic [31:0]      offset;
        logic [31:0]      length;
        logic [LinkW-1:0] link;
    } t_seg;
endpackage

[hw/rtl/mhfa_if.sv]
`timescale 1ns / 1ps
interface mhfa_req_if;
    logic valid;
    logic ready;
    mhfa_pkg::t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface mhfa_rsp_if;
    logic valid;
    logic ready;
    mhfa_pkg::t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/mhfa_seg_ram.sv]
`timescale 1ns / 1ps
module mhfa_seg_ram (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [mhfa_pkg::SegW-1:0] i_waddr,
    input  mhfa_pkg::t_seg       i_wdata,
    input  logic [mhfa_pkg::SegW-1:0] i_raddr,
    output mhfa_pkg::t_seg       o_rdata
);
    import mhfa_pkg::*;
    t_seg r_mem [SegSlots];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/multi_heap_first_fit_allocator.sv]
`timescale 1ns / 1ps
// One request is handled at a time. The free list lives in a descriptor RAM with one
// read port and is walked one descriptor at a time, each read in S_RD and checked
// in S_EVAL. The walk stops after 64 descriptors. A finished result moves to an
// output register and waits there until it is taken. The next request is accepted
// meanwhile; its own result waits until the previous one is gone.
module multi_heap_first_fit_allocator (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    mhfa_req_if.sink   s_req,
    mhfa_rsp_if.source m_rsp
);
    import mhfa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_START = 9'b000000010,
        S_RD    = 9'b000000100,
        S_EVAL  = 9'b000001000,
        S_ALLOC = 9'b000010000,
        S_FREE  = 9'b000100000,
        S_WR2   = 9'b001000000,
        S_REL   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_limit;
    logic [LinkW-1:0] r_head, n_head;
    logic [SegSlots-1:0] r_spare, n_spare;
    logic [HeapSlots-1:0] r_present, n_present;
    t_req r_req;
    t_rsp r_rsp, n_rsp;
    t_rsp r_out;
    logic r_rvalid, n_rvalid;
    logic [31:0] r_size;
    logic [LinkW-1:0] r_ll, r_l, r_n, n_ll, n_l, n_n;
    t_seg r_sl, r_sn, n_sl, n_sn;
    logic [6:0] r_steps, n_steps;
    logic [LinkW-1:0] r_blk, r_pred, n_blk, n_pred;
    t_seg r_w2, n_w2;
    logic r_w2v, n_w2v;
    logic [31:0] r_blen, n_blen;

    logic we;
    logic [SegW-1:0] waddr, raddr;
    t_seg wdata, rdata;

    mhfa_seg_ram u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [LinkW-1:0] spare_idx;
    logic [3:0] hcount;
    logic [3:0] hidx;
    always_comb begin
        spare_idx = NilLink;
        for (int i = SegSlots - 1; i >= 0; i--) begin
            if (r_spare[i]) spare_idx = LinkW'(i);
        end
        hcount = '0;
        hidx = 4'(HeapSlots);
        for (int i = HeapSlots - 1; i >= 0; i--) begin
            if (r_present[i]) hcount = hcount + 4'd1;
            else hidx = 4'(i);
        end
    end

    logic [31:0] off32;
    logic lin, nin, mn, mp;
    assign off32 = {12'd0, r_req.blk_offset};
    assign lin = (r_l != NilLink) && (r_sl.heap == r_req.blk_heap);
    assign nin = (rdata.heap == r_req.blk_heap);
    assign mn = (r_n != NilLink) && (r_sn.heap == r_req.blk_heap) &&
                (off32 + {11'd0, r_req.blk_size} == r_sn.offset);
    assign mp = lin && (r_sl.offset + r_sl.length == off32);

    assign s_req.ready = (r_state == S_IDLE);
    assign m_rsp.valid = r_rvalid;
    assign m_rsp.data = r_out;

    always_comb begin
        n_state = r_state; n_head = r_head; n_spare = r_spare;
        n_present = r_present; n_rsp = r_rsp; n_rvalid = r_rvalid;
        n_ll = r_ll; n_l = r_l; n_n = r_n; n_sl = r_sl; n_sn = r_sn;
        n_steps = r_steps; n_blk = r_blk; n_pred = r_pred;
        n_w2 = r_w2; n_w2v = r_w2v; n_blen = r_blen;
        we = 1'b0; waddr = '0; wdata = '0; raddr = r_n[SegW-1:0];
        if (r_rvalid && m_rsp.ready) n_rvalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_req.valid && s_req.ready) n_state = S_START;
            end
            S_START: begin
                n_rsp = '0;
                n_ll = NilLink; n_l = NilLink; n_n = r_head; n_steps = '0;
                n_w2v = 1'b0;
                if (!r_req.kind && r_size > 32'(HeapBytes)) begin
                    n_rsp.status = ST_TOO_LARGE; n_state = S_DONE;
                end else if (r_req.kind && !r_present[r_req.blk_heap]) begin
                    n_rsp.status = ST_NO_HEAP; n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                raddr = r_n[SegW-1:0];
                if (r_n == NilLink || r_steps == 7'(SegSlots)) begin
                    n_n = NilLink;
                    n_state = r_req.kind ? S_FREE : S_ALLOC;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_sn = rdata;
                if (!r_req.kind) begin
                    if (r_size <= rdata.length) n_state = S_ALLOC;
                    else begin
                        n_ll = r_l; n_l = r_n; n_sl = rdata; n_n = rdata.link;
                        n_steps = r_steps + 7'd1; n_state = S_RD;
                    end
                end else if ((lin || nin) && (!lin || off32 > r_sl.offset) &&
                             (!nin || off32 < rdata.offset)) begin
                    n_state = S_FREE;
                end else begin
                    n_ll = r_l; n_l = r_n; n_sl = rdata; n_n = rdata.link;
                    n_steps = r_steps + 7'd1; n_state = S_RD;
                end
            end
            S_ALLOC: begin
                n_state = S_DONE;
                if (r_n == NilLink) begin
                    if (hcount >= r_limit || hidx == 4'(HeapSlots)) begin
                        n_rsp.status = ST_NO_HEAP;
                    end else if (spare_idx == NilLink) begin
                        n_rsp.status = ST_TABLE_FULL;
                    end else begin
                        n_present[hidx[2:0]] = 1'b1;
                        n_rsp.got_heap = hidx[2:0];
                        n_rsp.got_size = r_size[20:0];
                        n_rsp.heap_added = 1'b1;
                        we = 1'b1; waddr = spare_idx[SegW-1:0];
                        wdata.heap = hidx[2:0];
                        wdata.link = r_head;
                        if (r_size != 32'(HeapBytes)) begin
                            n_spare[spare_idx[SegW-1:0]] = 1'b0;
                            wdata.offset = r_size;
                            wdata.length = 32'(HeapBytes) - r_size;
                            n_head = spare_idx;
                        end
                    end
                end else begin
                    n_rsp.got_heap = r_sn.heap;
                    n_rsp.got_offset = r_sn.offset[19:0];
                    n_rsp.got_size = r_size[20:0];
                    if (r_sn.length != r_size) begin
                        we = 1'b1; waddr = r_n[SegW-1:0];
                        wdata = r_sn;
                        wdata.offset = r_sn.offset + r_size;
                        wdata.length = r_sn.length - r_size;
                    end else begin
                        n_spare[r_n[SegW-1:0]] = 1'b1;
                        if (r_l != NilLink) begin
                            we = 1'b1; waddr = r_l[SegW-1:0];
                            wdata = r_sl; wdata.link = r_sn.link;
                        end else n_head = r_sn.link;
                    end
                end
            end
            S_FREE: begin
                n_state = S_REL;
                if (mn && mp) begin
                    we = 1'b1; waddr = r_l[SegW-1:0]; wdata = r_sl;
                    wdata.length = r_sl.length + {11'd0, r_req.blk_size} + r_sn.length;
                    wdata.link = r_sn.link;
                    n_spare[r_n[SegW-1:0]] = 1'b1;
                    n_blk = r_l; n_pred = r_ll;
                end else if (mp) begin
                    we = 1'b1; waddr = r_l[SegW-1:0]; wdata = r_sl;
                    wdata.length = r_sl.length + {11'd0, r_req.blk_size};
                    n_blk = r_l; n_pred = r_ll;
                end else if (mn) begin
                    we = 1'b1; waddr = r_n[SegW-1:0]; wdata = r_sn;
                    wdata.offset = off32;
                    wdata.length = r_sn.length + {11'd0, r_req.blk_size};
                    n_blk = r_n; n_pred = r_l;
                end else if (spare_idx == NilLink) begin
                    n_rsp.status = ST_TABLE_FULL; n_state = S_DONE;
                end else begin
                    we = 1'b1; waddr = spare_idx[SegW-1:0];
                    wdata.heap = r_req.blk_heap; wdata.offset = off32;
                    wdata.length = {11'd0, r_req.blk_size}; wdata.link = r_n;
                    n_spare[spare_idx[SegW-1:0]] = 1'b0;
                    if (r_l != NilLink) begin
                        n_w2 = r_sl; n_w2.link = spare_idx; n_w2v = 1'b1;
                    end else n_head = spare_idx;
                    n_blk = spare_idx; n_pred = r_l;
                end
                n_blen = wdata.length;
                n_sn = wdata;
                if (r_l == n_pred && n_w2v) n_sl = n_w2;
            end
            S_REL: begin
                if (r_blen == 32'(HeapBytes)) begin
                    n_rsp.heap_released = 1'b1;
                    n_present[r_req.blk_heap] = 1'b0;
                    n_spare[r_blk[SegW-1:0]] = 1'b1;
                    n_w2v = 1'b0;
                    if (r_pred != NilLink) begin
                        we = 1'b1; waddr = r_pred[SegW-1:0];
                        wdata = r_sl;
                        wdata.link = r_sn.link;
                    end else n_head = r_sn.link;
                    n_state = S_DONE;
                end else begin
                    n_state = S_WR2;
                end
            end
            S_WR2: begin
                if (r_w2v) begin
                    we = 1'b1; waddr = r_l[SegW-1:0]; wdata = r_w2;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_rvalid) begin
                    n_rvalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The predecessor record used at release time is r_sl when it is l; when it is
    // ll, the copy kept in r_sll is loaded into r_sl in S_FREE, below.
    t_seg r_sll;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_limit <= 4'd8; r_head <= NilLink;
            r_spare <= '1; r_present <= '0; r_rvalid <= 1'b0; r_w2v <= 1'b0;
        end else begin
            r_state <= n_state; r_head <= n_head; r_spare <= n_spare;
            r_present <= n_present; r_rvalid <= n_rvalid; r_w2v <= n_w2v;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
        end
        if (s_req.valid && s_req.ready) begin
            r_req <= s_req.data;
            r_size <= ({8'd0, s_req.data.req_size} + 32'd3) & ~32'd3;
        end
        if (r_state == S_DONE && !r_rvalid) r_out <= r_rsp;
        r_rsp <= n_rsp; r_ll <= n_ll; r_l <= n_l; r_n <= n_n;
        r_sn <= n_sn; r_steps <= n_steps; r_blk <= n_blk; r_pred <= n_pred;
        r_w2 <= n_w2; r_blen <= n_blen;
        if (r_state == S_EVAL && n_state == S_RD) r_sll <= r_sl;
        if (r_state == S_FREE && n_pred == r_ll && r_ll != NilLink) r_sl <= r_sll;
        else r_sl <= n_sl;
    end
endmodule

[hw/rtl/mhfa_checker.sv]
`timescale 1ns / 1ps
module mhfa_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input mhfa_pkg::t_rsp rsp_data
);
    import mhfa_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result dropped while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while busy");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !(rsp_data.heap_added && rsp_data.heap_released))
        else $error("added and released together");
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_data.status != ST_OK |-> rsp_data.got_size == '0)
        else $error("failed request grants bytes");
endmodule

bind multi_heap_first_fit_allocator mhfa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(s_req.valid), .req_ready(s_req.ready),
    .rsp_valid(m_rsp.valid), .rsp_ready(m_rsp.ready), .rsp_data(m_rsp.data)
);

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import mhfa_pkg::*;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = 4'd0;

    mhfa_req_if req_bus();
    mhfa_rsp_if rsp_bus();

    multi_heap_first_fit_allocator u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_req(req_bus.sink),
        .m_rsp(rsp_bus.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_bus.valid = 1'b0;
        req_bus.data = '0;
        rsp_bus.ready = 1'b0;
    end

    // Predictor state: free segment list and heap bookkeeping.
    logic [2:0]       fl_heap [SegSlots];
    logic [31:0]      fl_off [SegSlots];
    logic [31:0]      fl_len [SegSlots];
    logic [LinkW-1:0] fl_link [SegSlots];
    logic [LinkW-1:0] fl_head;
    logic [SegSlots-1:0] fl_spare;
    logic [HeapSlots-1:0] heaps_in_use;
    logic [3:0] heap_cap;

    t_rsp pending_rsp[$];
    int mismatches = 0;
    int transfers_in = 0;
    int transfers_out = 0;

    // Live grants, used to build well-formed frees.
    typedef struct {
        logic [2:0]  heap;
        logic [19:0] off;
        logic [20:0] size;
    } t_grant;
    t_grant grants[$];

    function automatic logic [LinkW-1:0] first_spare();
        for (int i = 0; i < SegSlots; i++)
            if (fl_spare[i]) return LinkW'(i);
        return NilLink;
    endfunction

    function automatic t_rsp predict_alloc(logic [23:0] req);
        t_rsp r;
        logic [31:0] size;
        logic [LinkW-1:0] prev, cur, d;
        int steps, count, idx;
        r = '0;
        size = (32'(req) + 32'd3) & ~32'd3;
        if (size > HeapBytes) begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        prev = NilLink;
        cur = fl_head;
        steps = 0;
        while (cur < SegSlots && steps < SegSlots) begin
            if (size <= fl_len[cur]) break;
            prev = cur;
            cur = fl_link[cur];
            steps++;
        end
        if (cur >= SegSlots || steps >= SegSlots) begin
            count = 0;
            idx = -1;
            for (int i = 0; i < HeapSlots; i++) begin
                if (heaps_in_use[i]) count++;
                else if (idx < 0) idx = i;
            end
            if (count >= heap_cap || idx < 0) begin
                r.status = ST_NO_HEAP;
                return r;
            end
            d = first_spare();
            if (d == NilLink) begin
                r.status = ST_TABLE_FULL;
                return r;
            end
            fl_spare[d] = 1'b0;
            fl_heap[d] = 3'(idx);
            fl_off[d] = 0;
            fl_len[d] = HeapBytes;
            fl_link[d] = fl_head;
            fl_head = d;
            heaps_in_use[idx] = 1'b1;
            cur = d;
            prev = NilLink;
            r.heap_added = 1'b1;
        end
        r.status = ST_OK;
        r.got_heap = fl_heap[cur];
        r.got_offset = fl_off[cur][19:0];
        r.got_size = size[20:0];
        if (fl_len[cur] != size) begin
            fl_off[cur] += size;
            fl_len[cur] -= size;
        end else begin
            if (prev < SegSlots) fl_link[prev] = fl_link[cur];
            else fl_head = fl_link[cur];
            fl_spare[cur] = 1'b1;
        end
        return r;
    endfunction

    function automatic t_rsp predict_free(logic [2:0] h, logic [19:0] off20, logic [20:0] sz21);
        t_rsp r;
        logic [31:0] off, sz;
        logic [LinkW-1:0] ll, l, n, blk, pred, d, succ;
        int steps;
        bit lin, nin, mn, mp;
        r = '0;
        off = 32'(off20);
        sz = 32'(sz21);
        if (!heaps_in_use[h]) begin
            r.status = ST_NO_HEAP;
            return r;
        end
        ll = NilLink;
        l = NilLink;
        n = fl_head;
        steps = 0;
        while (n < SegSlots && steps < SegSlots) begin
            lin = l < SegSlots && fl_heap[l] == h;
            nin = fl_heap[n] == h;
            if ((lin || nin) && (!lin || off > fl_off[l]) && (!nin || off < fl_off[n]))
                break;
            ll = l;
            l = n;
            n = fl_link[n];
            steps++;
        end
        if (steps >= SegSlots) n = NilLink;
        mn = n < SegSlots && fl_heap[n] == h && off + sz == fl_off[n];
        mp = l < SegSlots && fl_heap[l] == h && fl_off[l] + fl_len[l] == off;
        if (mn && mp) begin
            fl_len[l] += sz + fl_len[n];
            fl_link[l] = fl_link[n];
            fl_spare[n] = 1'b1;
            blk = l;
            pred = ll;
        end else if (mp) begin
            fl_len[l] += sz;
            blk = l;
            pred = ll;
        end else if (mn) begin
            fl_off[n] = off;
            fl_len[n] += sz;
            blk = n;
            pred = l;
        end else begin
            d = first_spare();
            if (d == NilLink) begin
                r.status = ST_TABLE_FULL;
                return r;
            end
            fl_spare[d] = 1'b0;
            fl_heap[d] = h;
            fl_off[d] = off;
            fl_len[d] = sz;
            fl_link[d] = n;
            if (l < SegSlots) fl_link[l] = d;
            else fl_head = d;
            blk = d;
            pred = l;
        end
        r.status = ST_OK;
        if (fl_len[blk] == HeapBytes) begin
            succ = fl_link[blk];
            if (pred < SegSlots) fl_link[pred] = succ;
            else fl_head = succ;
            fl_spare[blk] = 1'b1;
            heaps_in_use[h] = 1'b0;
            r.heap_released = 1'b1;
        end
        return r;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic set_heap_cap(logic [3:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        heap_cap = v;
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        idle_cycles(200);
    endtask

    // Drives one transfer; fixed holds a typed-in expectation when use_fixed is set.
    task automatic send_item(t_req item, bit use_fixed, t_rsp fixed);
        t_rsp p;
        t_grant g;
        int wait_n;
        wait_n = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : 0;
        if (wait_n != 0) begin
            req_bus.valid <= 1'b0;
            idle_cycles(wait_n);
        end
        req_bus.valid <= 1'b1;
        req_bus.data <= item;
        do @(posedge i_clk); while (!req_bus.ready);
        transfers_in++;
        if (item.kind == OP_ALLOC) p = predict_alloc(item.req_size);
        else p = predict_free(item.blk_heap, item.blk_offset, item.blk_size);
        if (use_fixed && p != fixed)
            $display("note: predictor disagrees with typed expectation %h vs %h", p, fixed);
        pending_rsp.push_back(use_fixed ? fixed : p);
        if (item.kind == OP_ALLOC && p.status == ST_OK && p.got_size != 0) begin
            g.heap = p.got_heap;
            g.off = p.got_offset;
            g.size = p.got_size;
            grants.push_back(g);
        end
    endtask

    function automatic t_req mk_alloc(logic [23:0] sz);
        t_req t;
        t = '0;
        t.kind = OP_ALLOC;
        t.req_size = sz;
        t.blk_heap = 3'($urandom);
        t.blk_offset = 20'($urandom);
        t.blk_size = 21'($urandom);
        return t;
    endfunction

    function automatic t_req mk_free(logic [2:0] h, logic [19:0] o, logic [20:0] s);
        t_req t;
        t = '0;
        t.kind = OP_FREE;
        t.req_size = 24'($urandom);
        t.blk_heap = h;
        t.blk_offset = o;
        t.blk_size = s;
        return t;
    endfunction

    function automatic t_rsp mk_rsp(t_status st, logic [2:0] h, logic [19:0] o,
                                    logic [20:0] s, logic a, logic rel);
        t_rsp r;
        r.status = st;
        r.got_heap = h;
        r.got_offset = o;
        r.got_size = s;
        r.heap_added = a;
        r.heap_released = rel;
        return r;
    endfunction

    task automatic release_random_grant();
        int k;
        t_grant g;
        k = $urandom_range(0, grants.size() - 1);
        g = grants[k];
        grants.delete(k);
        send_item(mk_free(g.heap, g.off, g.size), 1'b0, '0);
    endtask

    // Result side: random stalls, in-order comparison.
    initial begin
        t_rsp want;
        int wait_n;
        @(posedge i_rst_n);
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (wait_n != 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_bus.valid);
            transfers_out++;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", rsp_bus.data);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_bus.data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: expected %p, got %p",
                                 transfers_out, want, rsp_bus.data);
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    typedef struct {
        t_req item;
        bit   fixed;
        t_rsp rsp;
    } t_row;

    initial begin
        t_row rows[$];
        logic [3:0] caps[5];
        int roll;
        t_grant g;

        caps = '{4'd1, 4'd3, 4'd0, 4'd15, 4'd8};
        fl_head = NilLink;
        fl_spare = '1;
        heaps_in_use = '0;
        heap_cap = 4'd8;
        for (int i = 0; i < SegSlots; i++) begin
            fl_heap[i] = '0;
            fl_off[i] = '0;
            fl_len[i] = '0;
            fl_link[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{mk_free(3'd0, 20'd0, 21'd4), 1, mk_rsp(ST_NO_HEAP, 0, 0, 0, 0, 0)});
        rows.push_back('{mk_alloc(24'hFFFFFF), 1, mk_rsp(ST_TOO_LARGE, 0, 0, 0, 0, 0)});
        rows.push_back('{mk_alloc(24'd1048577), 1, mk_rsp(ST_TOO_LARGE, 0, 0, 0, 0, 0)});
        rows.push_back('{mk_alloc(24'd1), 1, mk_rsp(ST_OK, 0, 0, 4, 1, 0)});
        rows.push_back('{mk_alloc(24'd0), 1, mk_rsp(ST_OK, 0, 4, 0, 0, 0)});
        rows.push_back('{mk_alloc(24'd1048576), 1, mk_rsp(ST_OK, 1, 0, 21'd1048576, 1, 0)});
        rows.push_back('{mk_alloc(24'd7), 0, '0});
        rows.push_back('{mk_free(3'd1, 20'd0, 21'd1048576), 1, mk_rsp(ST_OK, 0, 0, 0, 0, 1)});
        rows.push_back('{mk_free(3'd0, 20'd0, 21'd4), 0, '0});
        rows.push_back('{mk_free(3'd0, 20'd4, 21'd8), 0, '0});
        rows.push_back('{mk_free(3'd7, 20'hFFFFF, 21'h1FFFFF), 1,
                         mk_rsp(ST_NO_HEAP, 0, 0, 0, 0, 0)});
        rows.push_back('{mk_alloc(24'd1048573), 0, '0});
        rows.push_back('{mk_alloc(24'd100), 0, '0});
        rows.push_back('{mk_free(3'd0, 20'd500, 21'd12), 0, '0});
        rows.push_back('{mk_free(3'd0, 20'hFFFFF, 21'h1FFFFF), 0, '0});
        rows.push_back('{mk_alloc(24'h555555), 0, '0});
        rows.push_back('{mk_alloc(24'h0AAAAA), 0, '0});
        foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].rsp);
        grants.delete();
        drain();

        // Each phase uses a fresh heap cap; the sender waits for all results in drain().
        foreach (caps[p]) begin
            set_heap_cap(caps[p]);
            for (int n = 0; n < 370; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 45 || grants.size() == 0) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(mk_alloc(24'($urandom)), 1'b0, '0);
                    else if ($urandom_range(0, 9) == 0)
                        send_item(mk_alloc(24'($urandom_range(0, 1048576))), 1'b0, '0);
                    else
                        send_item(mk_alloc(24'($urandom_range(0, 40000))), 1'b0, '0);
                end else if (roll < 90) begin
                    release_random_grant();
                end else if (roll < 95) begin
                    send_item(mk_free(3'($urandom), 20'($urandom), 21'($urandom)), 1'b0, '0);
                end else begin
                    g = grants[$urandom_range(0, grants.size() - 1)];
                    send_item(mk_free(g.heap, g.off + 20'($urandom_range(0, 8) * 4),
                                      21'($urandom_range(1, 64) * 4)), 1'b0, '0);
                end
            end
            while (grants.size() != 0) release_random_grant();
            drain();
        end

        $display("Covered %0d transfers in, %0d results out, heap caps 1, 3, 0, 15 and 8,",
                 transfers_in, transfers_out);
        $display("with table extremes, well-formed frees, bogus frees and overlaps.");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
